// ===== rtl/core/first_unique_symbol_tracker_top_defines.svh =====
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_TOP_DEFINES_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define FUT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("first unique tracker: same-cycle check failed");

// next-cycle implication, masked during reset
`define FUT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("first unique tracker: next-cycle check failed");

// next-cycle implication, live through reset
`define FUT_ASSERT_NXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("first unique tracker: reset check failed");

`endif

// ===== rtl/core/futrk_pkg.sv =====
`default_nettype none

package futrk_pkg;

  localparam int SYMBOL_W         = 8;
  localparam int ALPHABET_DEFAULT = 256;

  // saturating occurrence count codes
  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                restart;
  } in_t;

  typedef struct packed {
    logic                found;
    logic [SYMBOL_W-1:0] first_unique;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_Q_RD,
    ST_C_RD,
    ST_CHK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic pop;
    logic load_head;
    logic cnt_rd_queue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pop_needed;
    logic head_repeated;
    logic pop_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/futrk_ram.sv =====
`default_nettype none

module futrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/futrk_ctrl.sv =====
`default_nettype none

module futrk_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire futrk_pkg::status_t status,
  output      futrk_pkg::cmd_t   cmd
);

  import futrk_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.pop_needed) begin
          cmd.pop    = 1'b1;
          state_next = status.pop_last ? ST_EMIT : ST_Q_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_Q_RD: begin
        state_next = ST_C_RD;
      end
      ST_C_RD: begin
        cmd.load_head    = 1'b1;
        cmd.cnt_rd_queue = 1'b1;
        state_next       = ST_CHK;
      end
      ST_CHK: begin
        if (status.head_repeated) begin
          cmd.pop    = 1'b1;
          state_next = status.pop_last ? ST_EMIT : ST_Q_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/futrk_dp.sv =====
`default_nettype none

module futrk_dp #(
  parameter int ALPHABET = futrk_pkg::ALPHABET_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire futrk_pkg::in_t     in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      futrk_pkg::out_t    out_data,
  input  wire futrk_pkg::cmd_t    cmd,
  output      futrk_pkg::status_t status
);

  import futrk_pkg::*;

  localparam int AW = $clog2(ALPHABET);
  localparam int FW = $clog2(ALPHABET + 1);

  logic [SYMBOL_W-1:0] sym_reg;
  logic                sym_ok;
  logic [ALPHABET-1:0] seen_valid;
  logic [AW-1:0]       head;
  logic [AW-1:0]       tail;
  logic [FW-1:0]       fill;
  logic [SYMBOL_W-1:0] head_sym;

  logic [1:0]          cnt_q;
  logic [SYMBOL_W-1:0] q_rdata;
  logic [1:0]          cur_cnt;
  logic [1:0]          head_cnt;
  logic [1:0]          cnt_wdata;
  logic [AW-1:0]       cnt_raddr;
  logic                cnt_we;
  logic                push;
  logic                in_range;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] res;
    res = (idx == AW'(ALPHABET - 1)) ? '0 : idx + 1'b1;
    return res;
  endfunction

  // occurrence counts, qualified by seen_valid
  futrk_ram #(
    .WIDTH (2),
    .DEPTH (ALPHABET)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (sym_reg[AW-1:0]),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  // symbols in order of first occurrence
  futrk_ram #(
    .WIDTH (SYMBOL_W),
    .DEPTH (ALPHABET)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail),
    .wdata (sym_reg),
    .raddr (head),
    .rdata (q_rdata)
  );

  assign in_range  = (9'(in_data.symbol) < 9'(ALPHABET));
  assign cur_cnt   = seen_valid[sym_reg[AW-1:0]] ? cnt_q : CNT_ZERO;
  assign head_cnt  = seen_valid[head_sym[AW-1:0]] ? cnt_q : CNT_ZERO;
  assign cnt_raddr = cmd.cnt_rd_queue ? q_rdata[AW-1:0] : in_data.symbol[AW-1:0];
  assign cnt_we    = cmd.update && sym_ok;
  assign cnt_wdata = (cur_cnt == CNT_ZERO) ? CNT_ONE : CNT_MANY;
  assign push      = cmd.update && sym_ok && (cur_cnt == CNT_ZERO) && (fill < FW'(ALPHABET));

  assign status.pop_needed    = sym_ok && (cur_cnt == CNT_ONE) && (fill != '0)
                                && (head_sym == sym_reg);
  assign status.head_repeated = (head_cnt == CNT_MANY);
  assign status.pop_last      = (fill == FW'(1));
  assign status.out_free      = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid <= '0;
      head       <= '0;
      tail       <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept && in_data.restart) begin
        seen_valid <= '0;
        head       <= '0;
        tail       <= '0;
        fill       <= '0;
      end
      if (cnt_we) begin
        seen_valid[sym_reg[AW-1:0]] <= 1'b1;
      end
      if (push) begin
        tail <= idx_inc(tail);
        fill <= fill + 1'b1;
      end
      if (cmd.pop) begin
        head <= idx_inc(head);
        fill <= fill - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_reg <= in_data.symbol;
      sym_ok  <= in_range;
    end
    if (push && (fill == '0)) begin
      head_sym <= sym_reg;
    end else if (cmd.load_head) begin
      head_sym <= q_rdata;
    end
    if (cmd.emit) begin
      out_data.found        <= (fill != '0);
      out_data.first_unique <= (fill != '0) ? head_sym : '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_unique_symbol_tracker_top.sv =====
// result: registered in the emit state after the update state when the queue head stays put
// each drop that leaves entries in the queue adds the queue read, count read and check states
// one transaction at a time, next accepted in the emit state after the count write-back
// drops happen at most once per symbol per stream, so extra cycles amortise over the stream
// reset: synchronous, clears control and per-symbol valid flags at once, no clearing pass
`default_nettype none

module first_unique_symbol_tracker_top #(
  parameter int ALPHABET = futrk_pkg::ALPHABET_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire futrk_pkg::in_t  in_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      futrk_pkg::out_t out_data
);

  import futrk_pkg::*;

  cmd_t    cmd;
  status_t status;

  futrk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  futrk_dp #(
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/futrk_chk.sv =====
`default_nettype none
`include "first_unique_symbol_tracker_top_defines.svh"

module futrk_chk (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire futrk_pkg::out_t out_data
);

  import futrk_pkg::*;

  // not-found result carries a zero symbol
  `FUT_ASSERT_IMP(a_notfound_zero, out_valid && !out_data.found, out_data.first_unique == '0)

  // one transaction in flight: no second accept right after one
  `FUT_ASSERT_NXT(a_accept_gap, in_valid && in_ready, !in_ready)

  // stalled result holds
  `FUT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // no result straight out of reset
  `FUT_ASSERT_NXT_RST(a_reset_empty, rst, !out_valid)

endmodule

bind first_unique_symbol_tracker_top futrk_chk u_chk (.*);

`default_nettype wire
